### design/ordered_array_list_engine_top_defines.svh
// Assertion macros shared by the ordered array list engine RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef ORDERED_ARRAY_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define OALE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define OALE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/oale_pkg.sv
// Package for the ordered array list engine: field widths, payload types,
// action and status codes. Depends on nothing.
package oale_pkg;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FPOS_W   = 7;
  localparam int FILL_W   = 8;

  typedef logic [ACTION_W-1:0]       action_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [STATUS_W-1:0]       status_t;
  typedef logic [FPOS_W-1:0]         fpos_t;
  typedef logic [FILL_W-1:0]         fill_t;

  // Request actions
  localparam action_t ACT_INSERT_AT = 3'd0;
  localparam action_t ACT_DELETE_AT = 3'd1;
  localparam action_t ACT_DELETE_VAL = 3'd2;
  localparam action_t ACT_READ_AT   = 3'd3;
  localparam action_t ACT_FIND_VAL  = 3'd4;

  // Result status
  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_FULL      = 2'd1;
  localparam status_t STAT_BAD_POS   = 2'd2;
  localparam status_t STAT_NOT_FOUND = 2'd3;

endpackage

### design/oale_if.sv
// Valid/ready channel interfaces for the ordered array list engine:
// request channel and result channel. Depends on oale_pkg.
interface oale_req_if;
  import oale_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  pos_t    position;
  value_t  value;

  modport source (output valid, output action, output position, output value, input ready);
  modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface oale_rsp_if;
  import oale_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  fpos_t   found_position;
  value_t  read_value;
  fill_t   fill_count;

  modport source (output valid, output status, output found_position,
                  output read_value, output fill_count, input ready);
  modport sink   (input valid, input status, input found_position,
                  input read_value, input fill_count, output ready);
endinterface

### design/ordered_array_list_engine_top.sv
// Ordered array list engine: list of signed values in one RAM plus a fill count.
// Flow: a reject goes straight to the finish step; a read passes the read step; insert
// moves entries from the tail down to the position one place up; delete at moves later
// entries one place down; delete value and find walk the whole list, one entry per
// cycle. One request at a time, the next taken only once the result has loaded.
// Sync reset clears count and control, not the RAM. Needs oale_pkg, oale_if, oale_ram.
`include "ordered_array_list_engine_top_defines.svh"

module ordered_array_list_engine_top #(
  parameter int DEPTH = 128
) (
  input logic clk,
  input logic rst,
  oale_req_if.sink   req,
  oale_rsp_if.source rsp
);
  import oale_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // Controller states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [CW-1:0] pend_idx;
  logic          pend;
  logic          found;
  logic [AW-1:0] hit;
  action_t       op;
  logic [CW-1:0] pos_q;
  logic [VALUE_W-1:0] val_q;

  status_t       res_status;
  fpos_t         res_fpos;
  logic [VALUE_W-1:0] res_rval;

  logic          out_valid;
  status_t       out_status;
  fpos_t         out_fpos;
  logic [VALUE_W-1:0] out_rval;
  fill_t         out_fill;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CW-1:0]   ptr_dec;
  logic [CW-1:0]   pend_dec;

  assign pos_ext  = CMPW'(req.position);
  assign cnt_ext  = CMPW'(count);
  assign ptr_dec  = ptr - CW'(1);
  assign pend_dec = pend_idx - CW'(1);

  oale_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Steer RAM read and write ports by state
  always_comb begin
    ram_raddr = pos_ext[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = pend_idx[AW-1:0];
    ram_wdata = ram_rdata;
    case (state)
      S_WALK: begin
        ram_raddr = ptr[AW-1:0];
        ram_waddr = pend_dec[AW-1:0];
        ram_we    = pend && found && (op != ACT_FIND_VAL);
      end
      S_UP: begin
        ram_raddr = ptr_dec[AW-1:0];
        if (pend) begin
          ram_we = 1'b1;
        end else if (ptr == pos_q) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[AW-1:0];
          ram_wdata = val_q;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer: decode request, walk the list, hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless the finish step reloads it
      if (rsp.valid && rsp.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op         <= req.action;
            val_q      <= req.value;
            pos_q      <= CW'(pos_ext);
            res_fpos   <= '0;
            res_rval   <= '0;
            pend       <= 1'b0;
            case (req.action)
              ACT_INSERT_AT: begin
                if (count == CW'(DEPTH)) begin
                  res_status <= STAT_FULL;
                  state      <= S_FIN;
                end else if (pos_ext > cnt_ext) begin
                  res_status <= STAT_BAD_POS;
                  state      <= S_FIN;
                end else begin
                  res_status <= STAT_OK;
                  ptr        <= count;
                  state      <= S_UP;
                end
              end
              ACT_DELETE_AT: begin
                if (pos_ext >= cnt_ext) begin
                  res_status <= STAT_BAD_POS;
                  state      <= S_FIN;
                end else begin
                  res_status <= STAT_OK;
                  found      <= 1'b1;
                  hit        <= pos_ext[AW-1:0];
                  ptr        <= CW'(pos_ext) + CW'(1);
                  state      <= S_WALK;
                end
              end
              ACT_DELETE_VAL, ACT_FIND_VAL: begin
                res_status <= STAT_OK;
                found      <= 1'b0;
                ptr        <= '0;
                state      <= S_WALK;
              end
              ACT_READ_AT: begin
                if (pos_ext >= cnt_ext) begin
                  res_status <= STAT_BAD_POS;
                  state      <= S_FIN;
                end else begin
                  res_status <= STAT_OK;
                  state      <= S_RD;
                end
              end
              default: begin
                res_status <= STAT_BAD_POS;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_WALK: begin
          // Issue ascending reads; compare or shift down in the next cycle
          if (ptr < count) begin
            pend     <= 1'b1;
            pend_idx <= ptr;
            ptr      <= ptr + CW'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend && !found && (ram_rdata == val_q)) begin
            found <= 1'b1;
            hit   <= pend_idx[AW-1:0];
          end
          if (!pend && (ptr >= count)) begin
            state <= S_FIN;
            if (found) begin
              res_fpos <= FPOS_W'(hit);
              if (op != ACT_FIND_VAL) begin
                count <= count - CW'(1);
              end
            end else begin
              res_status <= STAT_NOT_FOUND;
            end
          end
        end
        S_UP: begin
          // Issue descending reads; write each entry one place up
          if (ptr > pos_q) begin
            pend     <= 1'b1;
            pend_idx <= ptr;
            ptr      <= ptr_dec;
          end else begin
            pend <= 1'b0;
          end
          if (!pend && (ptr == pos_q)) begin
            count <= count + CW'(1);
            state <= S_FIN;
          end
        end
        S_RD: begin
          res_rval <= ram_rdata;
          state    <= S_FIN;
        end
        S_FIN: begin
          // Load the output register once it is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_fpos   <= res_fpos;
            out_rval   <= res_rval;
            out_fill   <= FILL_W'(count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.found_position = out_fpos;
  assign rsp.read_value     = out_rval;
  assign rsp.fill_count     = out_fill;

  // Checks
  `OALE_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= CW'(DEPTH), "count above capacity")
  `OALE_ASSERT_NOW(a_no_idle_write, clk, rst, state == S_IDLE, !ram_we, "RAM write while idle")
  `OALE_ASSERT_NEXT(a_accept_busy, clk, rst, req.valid && req.ready, state != S_IDLE, "stuck idle")
  `OALE_ASSERT_NOW(a_result_from_fin, clk, rst, $rose(out_valid), $past(state) == S_FIN, "early result")
  `OALE_ASSERT_NOW(a_pend_in_walk, clk, rst, pend, state == S_WALK || state == S_UP, "stray read")

endmodule

### design/oale_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module oale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
